// ----- sv/lmpg_pkg.sv -----
// Package for the LFSR memory pattern generator/checker.
// Payload structs, configuration defaults and register indexes.
// No dependencies.
`default_nettype none

package lmpg_pkg;

  localparam int LFSR_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [LFSR_W-1:0] SEED_RESET = 16'h0001;
  localparam logic [LFSR_W-1:0] POLY_RESET = 16'h822B;

  // word index, taken from paddr[2]
  typedef enum logic {
    REG_SEED = 1'b0,
    REG_POLY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] read_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pattern_byte;
    logic              byte_mismatch;
    logic              region_match;
    logic              region_end;
  } out_item_t;

  typedef struct packed {
    logic [LFSR_W-1:0] seed;
    logic [LFSR_W-1:0] poly;
  } lfsr_cfg_t;

endpackage

`default_nettype wire

// ----- sv/lfsr_memory_pattern_gen_check_unit.sv -----
// Top level of the LFSR memory test pattern generator/checker.
// Instantiates lmpg_cfg_regs and lmpg_core; depends on lmpg_pkg.
//
//   channel | ports                      | moves
//   --------+----------------------------+-------------------------------
//   in      | in_valid/in_ready/in_data  | mode, read_byte, last_byte
//   out     | out_valid/out_ready/out_data | pattern, mismatch, match, end
//   cfg     | cfg_p* (APB-style, 32 bit) | seed @0x0, poly @0x4
//
// One item per cycle while out_ready is high; each result appears in the cycle after its item is taken.
// The LFSR step and byte compare sit between the state and the result register.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous reset: next item starts a region from the seed register.
`default_nettype none

module lfsr_memory_pattern_gen_check_unit #(
  parameter logic [lmpg_pkg::LFSR_W-1:0] SEED_INIT = lmpg_pkg::SEED_RESET,
  parameter logic [lmpg_pkg::LFSR_W-1:0] POLY_INIT = lmpg_pkg::POLY_RESET
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire lmpg_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lmpg_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [lmpg_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lmpg_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lmpg_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import lmpg_pkg::*;

  lfsr_cfg_t cfg;

  lmpg_cfg_regs #(
    .SEED_INIT (SEED_INIT),
    .POLY_INIT (POLY_INIT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lmpg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a mismatching byte can never report the region as clean
  a_miss_clears_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_mismatch |-> !out_data.region_match)
    else $error("mismatch reported with region_match set");

  // a held result blocks the input side
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // generate-mode items never flag a mismatch
  a_gen_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.mode |=> out_valid && !out_data.byte_mismatch)
    else $error("generate-mode item flagged a mismatch");

  // an accepted item always leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && (out_data.region_end == $past(in_data.last_byte)))
    else $error("accepted item produced no matching result");

endmodule

`default_nettype wire

// ----- sv/lmpg_cfg_regs.sv -----
// APB-style register file: start seed and feedback polynomial.
// Depends on lmpg_pkg.
`default_nettype none

module lmpg_cfg_regs #(
  parameter logic [lmpg_pkg::LFSR_W-1:0] SEED_INIT = lmpg_pkg::SEED_RESET,
  parameter logic [lmpg_pkg::LFSR_W-1:0] POLY_INIT = lmpg_pkg::POLY_RESET
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lmpg_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [lmpg_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [lmpg_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output lmpg_pkg::lfsr_cfg_t                  cfg
);
  import lmpg_pkg::*;

  logic [LFSR_W-1:0] seed_r;
  logic [LFSR_W-1:0] poly_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_INIT;
      poly_r <= POLY_INIT;
    end else if (wr_en) begin
      unique case (idx)
        REG_SEED: seed_r <= pwdata[LFSR_W-1:0];
        REG_POLY: poly_r <= pwdata[LFSR_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEED: prdata = {{(CFG_DATA_W-LFSR_W){1'b0}}, seed_r};
      REG_POLY: prdata = {{(CFG_DATA_W-LFSR_W){1'b0}}, poly_r};
      default:  prdata = '0;
    endcase
  end

  assign cfg = '{seed: seed_r, poly: poly_r};

endmodule

`default_nettype wire

// ----- sv/lmpg_core.sv -----
// Galois LFSR pattern generator, byte compare and result register.
// Depends on lmpg_pkg.
`default_nettype none

module lmpg_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lmpg_pkg::lfsr_cfg_t cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lmpg_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lmpg_pkg::out_item_t      out_data
);
  import lmpg_pkg::*;

  logic [LFSR_W-1:0] shift_r,    shift_nxt;
  logic              at_start_r;
  logic              match_r,    match_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;

  logic [LFSR_W-1:0] cur;
  logic              match_in;
  logic              miss;
  logic              accept;

  // output register frees up in the same cycle it is drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur      = at_start_r ? cfg.seed : shift_r;
    match_in = at_start_r ? 1'b1 : match_r;
    miss     = in_data.mode && (in_data.read_byte != cur[BYTE_W-1:0]);
    match_nxt = match_in && !miss;
    // Galois step: shift right, fold taps in when a one falls out
    shift_nxt = {1'b0, cur[LFSR_W-1:1]} ^ (cur[0] ? cfg.poly : '0);
    out_data_nxt.pattern_byte  = cur[BYTE_W-1:0];
    out_data_nxt.byte_mismatch = miss;
    out_data_nxt.region_match  = match_nxt;
    out_data_nxt.region_end    = in_data.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      at_start_r  <= 1'b1;
      match_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        shift_r    <= shift_nxt;
        at_start_r <= in_data.last_byte;
        match_r    <= match_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
